// File: hdl/htw_pkg.sv
// shared types, constants and bucket arithmetic for the hierarchical timer wheel
package htw_pkg;

   localparam int ENTRIES     = 64;
   localparam int NEAR_BITS   = 8;
   localparam int LEVEL_BITS  = 6;
   localparam int LEVELS      = 4;
   localparam int NEAR_SIZE   = 1 << NEAR_BITS;
   localparam int LEVEL_SIZE  = 1 << LEVEL_BITS;
   localparam int FAR_SIZE    = LEVELS * LEVEL_SIZE;
   // bucket id: top bit selects the far levels, low bits index near or far buckets
   localparam int BKT_W       = NEAR_BITS + 1;
   localparam int SLOT_W      = $clog2(ENTRIES);
   localparam int LINK_W      = $clog2(ENTRIES + 1);
   localparam logic [LINK_W-1:0] NONE = LINK_W'(ENTRIES);
   localparam int MAX_OUT     = 64;
   localparam int CNT_W       = $clog2(MAX_OUT + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   // divide by ten: multiply by reciprocal, keep bits from 35 up
   localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
   localparam int QUOT_SHIFT  = 35;
   localparam int QUOT_W      = 64 - QUOT_SHIFT;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic RK_EXPIRED  = 1'b0;
   localparam logic RK_REJECTED = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [31:0]        owner_handle;
      logic signed [31:0] session_id;
      logic signed [31:0] delay_ms;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [31:0]        expired_handle;
      logic signed [31:0] expired_session;
      logic               last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      CL_NOP,
      CL_NOW,
      CL_ADD,
      CL_TICK,
      CL_CANCEL
   } cls_type;

   typedef struct packed {
      cls_type             cls;
      logic [31:0]         handle;
      logic [31:0]         session;
      logic [QUOT_W-1:0]   quot;
   } job_type;

   typedef struct packed {
      logic             move;
      logic [BKT_W-1:0] bkt;
   } move_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_SCAN,
      S_FILE,
      S_FILE_W,
      S_FILE_L,
      S_DSP,
      S_DSP_H,
      S_DSP_R,
      S_DSP_E,
      S_ADV,
      S_MV,
      S_MV_H,
      S_MV_R,
      S_MV_N,
      S_CAN_B,
      S_CAN_H,
      S_CAN_R,
      S_CAN_C,
      S_FINISH
   } state_type;

   // bucket that a timer expiring at e belongs in, seen from tick now
   function automatic logic [BKT_W-1:0] file_bucket(input logic [31:0] e,
                                                    input logic [31:0] now);
      logic [BKT_W-1:0] b;
      logic [1:0]       lvl;
      logic [31:0]      m;
      logic [LEVEL_BITS-1:0] idx;
      lvl = 2'(LEVELS - 1);
      for (int i = LEVELS - 2; i >= 0; i--) begin
         m = 32'((64'd1 << (NEAR_BITS + (i + 1) * LEVEL_BITS)) - 64'd1);
         if ((e | m) == (now | m)) begin
            lvl = 2'(i);
         end
      end
      idx = LEVEL_BITS'(e >> (NEAR_BITS + int'(lvl) * LEVEL_BITS));
      b = {1'b1, lvl, idx};
      if (e[31:NEAR_BITS] == now[31:NEAR_BITS]) begin
         b = {1'b0, e[NEAR_BITS-1:0]};
      end
      return b;
   endfunction

   // far bucket to redistribute once the counter has moved on to ct
   function automatic move_type cascade(input logic [31:0] ct);
      move_type r;
      logic     stop;
      logic [31:0] m;
      logic [LEVEL_BITS-1:0] idx;
      r.move = 1'b0;
      r.bkt  = {1'b1, 2'(LEVELS - 1), LEVEL_BITS'(0)};
      stop   = 1'b0;
      if (ct == 32'd0) begin
         r.move = 1'b1;
      end else begin
         for (int i = 0; i < LEVELS; i++) begin
            m   = 32'((64'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 64'd1);
            idx = LEVEL_BITS'(ct >> (NEAR_BITS + i * LEVEL_BITS));
            if (!stop) begin
               if ((ct & m) != 32'd0) begin
                  stop = 1'b1;
               end else if (idx != LEVEL_BITS'(0)) begin
                  r.move = 1'b1;
                  r.bkt  = {1'b1, 2'(i), idx};
                  stop   = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

endpackage

// File: hdl/htw_front.sv
// input stage: takes request beats, classifies them and divides the delay by ten
module htw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  htw_pkg::req_type  req_data,
   output logic              job_vld,
   input  logic              job_rdy,
   output htw_pkg::job_type  job
);

   logic             vld_ff, vld_in;
   htw_pkg::job_type job_ff, job_in;
   logic [63:0]      prod;
   htw_pkg::cls_type cls;

   assign req_ready = !vld_ff || job_rdy;
   assign prod      = {32'd0, req_data.delay_ms} * {32'd0, htw_pkg::RECIP};

   always_comb begin
      case (req_data.operation)
         htw_pkg::OP_ADD: begin
            if (req_data.delay_ms == 32'sd0 || req_data.delay_ms[31]) begin
               cls = htw_pkg::CL_NOW;
            end else begin
               cls = htw_pkg::CL_ADD;
            end
         end
         htw_pkg::OP_TICK:   cls = htw_pkg::CL_TICK;
         htw_pkg::OP_CANCEL: cls = htw_pkg::CL_CANCEL;
         default:            cls = htw_pkg::CL_NOP;
      endcase
   end

   always_comb begin
      vld_in = vld_ff && !job_rdy;
      job_in = job_ff;
      if (req_valid && req_ready) begin
         vld_in         = 1'b1;
         job_in.cls     = cls;
         job_in.handle  = req_data.owner_handle;
         job_in.session = req_data.session_id;
         job_in.quot    = prod[htw_pkg::QUOT_SHIFT+htw_pkg::QUOT_W-1:htw_pkg::QUOT_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      job_ff <= job_in;
   end

   assign job_vld = vld_ff;
   assign job     = job_ff;

endmodule

// File: hdl/htw_queue.sv
// short job queue between the classifying front and the wheel engine
module htw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   output logic              in_rdy,
   input  htw_pkg::job_type  in_job,
   output logic              out_vld,
   input  logic              out_rdy,
   output htw_pkg::job_type  out_job
);

   htw_pkg::job_type            mem_ff [htw_pkg::QUEUE_DEPTH];
   logic [htw_pkg::Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [htw_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic                        push, pop;

   assign in_rdy  = cnt_ff != htw_pkg::Q_CNT_W'(htw_pkg::QUEUE_DEPTH);
   assign out_vld = cnt_ff != '0;
   assign out_job = mem_ff[rd_ff];
   assign push    = in_vld && in_rdy;
   assign pop     = out_vld && out_rdy;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == htw_pkg::Q_PTR_W'(htw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == htw_pkg::Q_PTR_W'(htw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_job;
      end
   end

endmodule

// File: hdl/htw_engine.sv
// wheel engine: bucket and slot memories, sequencer for add, tick and cancel
module htw_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_vld,
   output logic              job_rdy,
   input  htw_pkg::job_type  job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output htw_pkg::rsp_type  rsp_data
);

   localparam int BKTS = 1 << htw_pkg::BKT_W;

   htw_pkg::state_type state_ff, state_in;
   htw_pkg::job_type   job_ff, job_in;
   logic [31:0]        tick_ff, tick_in;
   logic [htw_pkg::ENTRIES-1:0]   free_ff, free_in;
   logic [htw_pkg::SLOT_W-1:0] s_ff, s_in, scan_ff, scan_in;
   logic [htw_pkg::LINK_W-1:0] nx_ff, nx_in, prev_ff, prev_in;
   logic [31:0]        e_ff, e_in;
   logic [htw_pkg::BKT_W-1:0] tb_ff, tb_in, mb_ff, mb_in, cb_ff, cb_in;
   logic               phase_ff, phase_in, cas_ff, cas_in;
   logic [htw_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic               pend_vld_ff, pend_vld_in, rsp_vld_ff, rsp_vld_in;
   htw_pkg::rsp_type   pend_ff, pend_in, rsp_ff, rsp_in;

   logic [htw_pkg::LINK_W-1:0] first_mem [BKTS];
   logic [htw_pkg::SLOT_W-1:0] last_mem  [BKTS];
   logic [htw_pkg::LINK_W-1:0] link_mem  [htw_pkg::ENTRIES];
   logic [31:0]                exp_mem   [htw_pkg::ENTRIES];
   logic [31:0]                own_mem   [htw_pkg::ENTRIES];
   logic [31:0]                ses_mem   [htw_pkg::ENTRIES];
   logic [htw_pkg::LINK_W-1:0] first_rd_ff, lnk_rd_ff;
   logic [htw_pkg::SLOT_W-1:0] last_rd_ff;
   logic [31:0]                exp_rd_ff, own_rd_ff, ses_rd_ff;

   logic [htw_pkg::BKT_W-1:0]  bkt_sel, file_bkt;
   htw_pkg::move_type          adv_mv;
   logic [31:0]                e_new;
   logic head_ok, lnk_end, nx_end, cnt_full, out_free, can_push, dsp_go;
   logic slot_is_free, scan_last, cb_last, cmatch;
   logic first_we, last_we, link_we, slot_we, emit, flush;
   logic [htw_pkg::LINK_W-1:0] first_wd, link_wd;
   logic [htw_pkg::SLOT_W-1:0] last_wd, link_wa;
   htw_pkg::rsp_type           emit_d;

   assign file_bkt     = htw_pkg::file_bucket(e_ff, tick_ff);
   assign adv_mv       = htw_pkg::cascade(tick_ff + 32'd1);
   assign e_new        = tick_ff + 32'(job_ff.quot);
   assign head_ok      = first_rd_ff != htw_pkg::NONE;
   assign lnk_end      = lnk_rd_ff == htw_pkg::NONE;
   assign nx_end       = nx_ff == htw_pkg::NONE;
   assign cnt_full     = cnt_ff >= htw_pkg::CNT_W'(htw_pkg::MAX_OUT);
   assign out_free     = !rsp_vld_ff || rsp_ready;
   assign can_push     = !pend_vld_ff || out_free;
   assign dsp_go       = cnt_full || can_push;
   assign slot_is_free = free_ff[scan_ff];
   assign scan_last    = scan_ff == htw_pkg::SLOT_W'(htw_pkg::ENTRIES - 1);
   assign cb_last      = &cb_ff;
   assign cmatch       = (own_rd_ff == job_ff.handle) && (ses_rd_ff == job_ff.session);
   assign job_rdy      = state_ff == htw_pkg::S_IDLE;
   assign rsp_valid    = rsp_vld_ff;
   assign rsp_data     = rsp_ff;

   // bucket address shared by the head and tail accesses
   always_comb begin
      case (state_ff)
         htw_pkg::S_FILE:   bkt_sel = file_bkt;
         htw_pkg::S_FILE_W: bkt_sel = tb_ff;
         htw_pkg::S_DSP,
         htw_pkg::S_DSP_H:  bkt_sel = {1'b0, tick_ff[htw_pkg::NEAR_BITS-1:0]};
         htw_pkg::S_MV,
         htw_pkg::S_MV_H:   bkt_sel = mb_ff;
         default:           bkt_sel = cb_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htw_pkg::S_CLEAR: begin
            if (cb_last) begin
               state_in = htw_pkg::S_IDLE;
            end
         end
         htw_pkg::S_IDLE: begin
            if (job_vld) begin
               case (job.cls)
                  htw_pkg::CL_NOW:    state_in = htw_pkg::S_FINISH;
                  htw_pkg::CL_ADD:    state_in = htw_pkg::S_ADD_SCAN;
                  htw_pkg::CL_TICK:   state_in = htw_pkg::S_DSP;
                  htw_pkg::CL_CANCEL: state_in = htw_pkg::S_CAN_B;
                  default:            state_in = htw_pkg::S_IDLE;
               endcase
            end
         end
         htw_pkg::S_ADD_SCAN: begin
            if (slot_is_free) begin
               state_in = htw_pkg::S_FILE;
            end else if (scan_last) begin
               state_in = htw_pkg::S_FINISH;
            end
         end
         htw_pkg::S_FILE:   state_in = htw_pkg::S_FILE_W;
         htw_pkg::S_FILE_W: state_in = htw_pkg::S_FILE_L;
         htw_pkg::S_FILE_L: begin
            if (!cas_ff) begin
               state_in = htw_pkg::S_FINISH;
            end else if (nx_end) begin
               state_in = htw_pkg::S_DSP;
            end else begin
               state_in = htw_pkg::S_MV_R;
            end
         end
         htw_pkg::S_DSP:   state_in = htw_pkg::S_DSP_H;
         htw_pkg::S_DSP_H: begin
            if (head_ok) begin
               state_in = htw_pkg::S_DSP_R;
            end else begin
               state_in = phase_ff ? htw_pkg::S_FINISH : htw_pkg::S_ADV;
            end
         end
         htw_pkg::S_DSP_R: state_in = htw_pkg::S_DSP_E;
         htw_pkg::S_DSP_E: begin
            if (dsp_go) begin
               if (!lnk_end) begin
                  state_in = htw_pkg::S_DSP_R;
               end else begin
                  state_in = phase_ff ? htw_pkg::S_FINISH : htw_pkg::S_ADV;
               end
            end
         end
         htw_pkg::S_ADV:  state_in = adv_mv.move ? htw_pkg::S_MV : htw_pkg::S_DSP;
         htw_pkg::S_MV:   state_in = htw_pkg::S_MV_H;
         htw_pkg::S_MV_H: state_in = head_ok ? htw_pkg::S_MV_R : htw_pkg::S_DSP;
         htw_pkg::S_MV_R: state_in = htw_pkg::S_MV_N;
         htw_pkg::S_MV_N: state_in = htw_pkg::S_FILE;
         htw_pkg::S_CAN_B: state_in = htw_pkg::S_CAN_H;
         htw_pkg::S_CAN_H: begin
            if (head_ok) begin
               state_in = htw_pkg::S_CAN_R;
            end else begin
               state_in = cb_last ? htw_pkg::S_FINISH : htw_pkg::S_CAN_B;
            end
         end
         htw_pkg::S_CAN_R: state_in = htw_pkg::S_CAN_C;
         htw_pkg::S_CAN_C: begin
            if (cmatch) begin
               state_in = htw_pkg::S_FINISH;
            end else if (!lnk_end) begin
               state_in = htw_pkg::S_CAN_R;
            end else begin
               state_in = cb_last ? htw_pkg::S_FINISH : htw_pkg::S_CAN_B;
            end
         end
         htw_pkg::S_FINISH: begin
            if (can_push) begin
               state_in = htw_pkg::S_IDLE;
            end
         end
         default: state_in = htw_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      job_in      = job_ff;
      tick_in     = tick_ff;
      free_in     = free_ff;
      s_in        = s_ff;
      nx_in       = nx_ff;
      prev_in     = prev_ff;
      e_in        = e_ff;
      tb_in       = tb_ff;
      mb_in       = mb_ff;
      cb_in       = cb_ff;
      scan_in     = scan_ff;
      phase_in    = phase_ff;
      cas_in      = cas_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      first_we    = 1'b0;
      first_wd    = htw_pkg::NONE;
      last_we     = 1'b0;
      last_wd     = s_ff;
      link_we     = 1'b0;
      link_wa     = s_ff;
      link_wd     = htw_pkg::NONE;
      slot_we     = 1'b0;
      emit        = 1'b0;
      emit_d      = '{htw_pkg::RK_EXPIRED, own_rd_ff, ses_rd_ff, 1'b0};
      flush       = 1'b0;
      case (state_ff)
         // one bucket head emptied per cycle after reset
         htw_pkg::S_CLEAR: begin
            first_we = 1'b1;
            if (!cb_last) begin
               cb_in = cb_ff + 1'b1;
            end
         end
         htw_pkg::S_IDLE: begin
            if (job_vld) begin
               job_in   = job;
               scan_in  = '0;
               cb_in    = '0;
               phase_in = 1'b0;
               if (job.cls == htw_pkg::CL_NOW) begin
                  emit   = 1'b1;
                  emit_d = '{htw_pkg::RK_EXPIRED, job.handle, job.session, 1'b0};
               end
            end
         end
         htw_pkg::S_ADD_SCAN: begin
            if (slot_is_free) begin
               free_in[scan_ff] = 1'b0;
               slot_we = 1'b1;
               s_in    = scan_ff;
               e_in    = e_new;
               cas_in  = 1'b0;
            end else if (scan_last) begin
               emit   = 1'b1;
               emit_d = '{htw_pkg::RK_REJECTED, job_ff.handle, job_ff.session, 1'b0};
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         htw_pkg::S_FILE: tb_in = file_bkt;
         htw_pkg::S_FILE_W: begin
            last_we = 1'b1;
            last_wd = s_ff;
            if (first_rd_ff == htw_pkg::NONE) begin
               first_we = 1'b1;
               first_wd = htw_pkg::LINK_W'(s_ff);
            end else begin
               link_we = 1'b1;
               link_wa = last_rd_ff;
               link_wd = htw_pkg::LINK_W'(s_ff);
            end
         end
         htw_pkg::S_FILE_L: begin
            link_we = 1'b1;
            link_wa = s_ff;
            link_wd = htw_pkg::NONE;
            if (cas_ff && !nx_end) begin
               s_in = nx_ff[htw_pkg::SLOT_W-1:0];
            end
         end
         htw_pkg::S_DSP_H, htw_pkg::S_MV_H: begin
            first_we = 1'b1;
            if (head_ok) begin
               s_in = first_rd_ff[htw_pkg::SLOT_W-1:0];
            end
         end
         htw_pkg::S_DSP_E: begin
            if (dsp_go) begin
               free_in[s_ff] = 1'b1;
               if (!cnt_full) begin
                  emit = 1'b1;
               end
               if (!lnk_end) begin
                  s_in = lnk_rd_ff[htw_pkg::SLOT_W-1:0];
               end
            end
         end
         htw_pkg::S_ADV: begin
            tick_in  = tick_ff + 32'd1;
            mb_in    = adv_mv.bkt;
            phase_in = 1'b1;
         end
         htw_pkg::S_MV_N: begin
            nx_in  = lnk_rd_ff;
            e_in   = exp_rd_ff;
            cas_in = 1'b1;
         end
         htw_pkg::S_CAN_H: begin
            if (head_ok) begin
               s_in    = first_rd_ff[htw_pkg::SLOT_W-1:0];
               prev_in = htw_pkg::NONE;
            end else if (!cb_last) begin
               cb_in = cb_ff + 1'b1;
            end
         end
         htw_pkg::S_CAN_C: begin
            if (cmatch) begin
               free_in[s_ff] = 1'b1;
               if (prev_ff == htw_pkg::NONE) begin
                  first_we = 1'b1;
                  first_wd = lnk_rd_ff;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff[htw_pkg::SLOT_W-1:0];
                  link_wd = lnk_rd_ff;
               end
               if (last_rd_ff == s_ff) begin
                  last_we = 1'b1;
                  last_wd = (prev_ff != htw_pkg::NONE) ? prev_ff[htw_pkg::SLOT_W-1:0] : '0;
               end
            end else begin
               prev_in = htw_pkg::LINK_W'(s_ff);
               if (!lnk_end) begin
                  s_in = lnk_rd_ff[htw_pkg::SLOT_W-1:0];
               end else if (!cb_last) begin
                  cb_in = cb_ff + 1'b1;
               end
            end
         end
         htw_pkg::S_FINISH: begin
            if (can_push) begin
               flush  = 1'b1;
               cnt_in = '0;
            end
         end
         default: begin
         end
      endcase
      // the newest result waits in pend until we know whether it closes the run
      if (emit) begin
         if (pend_vld_ff) begin
            rsp_in             = pend_ff;
            rsp_in.last_of_run = 1'b0;
            rsp_vld_in         = 1'b1;
         end
         pend_in     = emit_d;
         pend_vld_in = 1'b1;
         cnt_in      = cnt_ff + 1'b1;
      end
      if (flush && pend_vld_ff) begin
         rsp_in             = pend_ff;
         rsp_in.last_of_run = 1'b1;
         rsp_vld_in         = 1'b1;
         pend_vld_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= htw_pkg::S_CLEAR;
         tick_ff     <= '0;
         free_ff     <= '1;
         cb_ff       <= '0;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         free_ff     <= free_in;
         cb_ff       <= cb_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      job_ff   <= job_in;
      s_ff     <= s_in;
      nx_ff    <= nx_in;
      prev_ff  <= prev_in;
      e_ff     <= e_in;
      tb_ff    <= tb_in;
      mb_ff    <= mb_in;
      scan_ff  <= scan_in;
      phase_ff <= phase_in;
      cas_ff   <= cas_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (first_we) first_mem[bkt_sel] <= first_wd;
      if (last_we)  last_mem[bkt_sel]  <= last_wd;
      first_rd_ff <= first_mem[bkt_sel];
      last_rd_ff  <= last_mem[bkt_sel];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      if (slot_we) begin
         exp_mem[scan_ff] <= e_new;
         own_mem[scan_ff] <= job_ff.handle;
         ses_mem[scan_ff] <= job_ff.session;
      end
      lnk_rd_ff <= link_mem[s_ff];
      exp_rd_ff <= exp_mem[s_ff];
      own_rd_ff <= own_mem[s_ff];
      ses_rd_ff <= ses_mem[s_ff];
   end

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == htw_pkg::S_IDLE |-> !pend_vld_ff)
      else $error("result still pending while idle");

   a_tick_only_adv: assert property (@(posedge clock) disable iff (reset)
      state_ff != htw_pkg::S_ADV |=> tick_ff == $past(tick_ff))
      else $error("tick counter moved outside advance");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      state_ff == htw_pkg::S_ADD_SCAN && free_ff[scan_ff] |=> !free_ff[$past(scan_ff)])
      else $error("claimed slot still marked free");

   a_finish_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == htw_pkg::S_FINISH && can_push |=> state_ff == htw_pkg::S_IDLE && !pend_vld_ff)
      else $error("run end not flushed");

endmodule

// File: hdl/hierarchical_timer_wheel.sv
// top level of the hierarchical timer wheel: front, job queue and engine
// Requests come in on req_valid/req_ready with req_data (add, tick, cancel).
// Each request beat is classified and queued; the engine works one job at a
// time and returns result beats on rsp_valid/rsp_ready, last_of_run marking
// the final beat of a job. An add takes a slot by scanning the free flags one
// slot a cycle and then files it in its bucket. A tick dispatches the current
// near bucket, advances the counter, redistributes a far bucket when one is due
// and dispatches the next near bucket; dispatch walks the bucket list one entry
// at a time through the slot memory. Cancel visits the 512 buckets in turn and
// compares each timer in them until one matches in handle and session.
// Up to four jobs queue ahead of the engine, so requests keep being taken while
// the engine or the receiver is busy. A stalled receiver holds the output
// register and the engine waits before its next result beat.
// Reset zeroes the tick counter and frees every slot at once; the engine then
// empties the 512 bucket heads in a clearing pass before it takes its first
// job, while the front and queue already accept request beats.
module hierarchical_timer_wheel (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  htw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output htw_pkg::rsp_type  rsp_data
);

   logic             f_vld, f_rdy, q_vld, q_rdy;
   htw_pkg::job_type f_job, q_job;

   htw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_vld   (f_vld),
      .job_rdy   (f_rdy),
      .job       (f_job)
   );

   htw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (f_vld),
      .in_rdy  (f_rdy),
      .in_job  (f_job),
      .out_vld (q_vld),
      .out_rdy (q_rdy),
      .out_job (q_job)
   );

   htw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_vld   (q_vld),
      .job_rdy   (q_rdy),
      .job       (q_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
